// File: src/command_line_lexer_core_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the command line lexer checker
// ---------------------------------------------------------------------------
`ifndef COMMAND_LINE_LEXER_CORE_MACROS_SVH
`define COMMAND_LINE_LEXER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define CLL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, quiet during reset
`define CLL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, also checked across reset
`define CLL_ASSERT_NXT_ANY(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/cll_pkg.sv
// ---------------------------------------------------------------------------
// cll_pkg
// types, codes and character classes shared by the command line lexer
// ---------------------------------------------------------------------------
package cll_pkg;

    // line offsets
    localparam int MAX_LINE  = 1024;
    localparam int POS_W     = 10;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'((MAX_LINE - 1 < 1023) ? MAX_LINE - 1 : 1023);

    // result word packing
    localparam int KIND_W   = 3;
    localparam int M_DATA_W = 24;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PIPE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REDIRECT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EOL      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LONG     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_OPER     = 3'd7;

    // characters of interest
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_INT       = 3'd1,
        MODE_FRAC      = 3'd2,
        MODE_IDENT     = 3'd3,
        MODE_OPT_MINUS = 3'd4,
        MODE_OPT_PLUS  = 3'd5,
        MODE_SHORT     = 3'd6,
        MODE_LONG      = 3'd7
    } mode_t;

    // one token descriptor
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  length;
        logic              last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // mode after c extends the open token, idle when c closes it
    function automatic mode_t extend_mode(input mode_t m, input logic [7:0] c);
        mode_t r;
        r = MODE_IDLE;
        case (m)
            MODE_INT: begin
                if (is_digit(c)) r = MODE_INT;
                else if (c == CH_DOT) r = MODE_FRAC;
            end
            MODE_FRAC:      if (is_digit(c)) r = MODE_FRAC;
            MODE_IDENT:     if (is_word(c)) r = MODE_IDENT;
            MODE_OPT_MINUS: begin
                if (c == CH_MINUS) r = MODE_LONG;
                else if (is_word(c)) r = MODE_SHORT;
            end
            MODE_OPT_PLUS: begin
                if (c == CH_PLUS) r = MODE_LONG;
                else if (is_word(c)) r = MODE_SHORT;
            end
            MODE_SHORT:     if (is_word(c)) r = MODE_SHORT;
            MODE_LONG:      if (is_word(c)) r = MODE_LONG;
            default:        r = MODE_IDLE;
        endcase
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] kind_of_mode(input mode_t m);
        logic [KIND_W-1:0] k;
        case (m)
            MODE_INT, MODE_FRAC: k = KIND_NUMBER;
            MODE_IDENT:          k = KIND_IDENT;
            MODE_LONG:           k = KIND_LONG;
            default:             k = KIND_SHORT;
        endcase
        return k;
    endfunction

endpackage

// File: src/command_line_lexer_core.sv
// Latency: from an empty queue, a word's first token is on m_* in the cycle after acceptance.
// Throughput: one character word per cycle while the four-entry queue holds at most one token;
// a word giving two or three tokens drains them one per cycle with m_tready high; input waits.
// Reset: aresetn low clears the lexer state, the line offset and the token queue.
// ---------------------------------------------------------------------------
// command_line_lexer_core
// lexes a console command line one character per word into token descriptors
// ---------------------------------------------------------------------------
module command_line_lexer_core
    import cll_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input characters
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] ch
    input  logic                s_tlast,   // line_end
    // token descriptors
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [2:0] token_kind, [12:3] token_start,
                                           // [22:13] token_length, [23] zero
    output logic                m_tlast    // run_last
);

    localparam int NCAND = 4;

    // lexer state
    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             lwe_reg, lwe_next;

    // token queue
    token_t     fifo_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;

    logic             accept, pop;
    logic [7:0]       c;
    logic [POS_W-1:0] end_pos;
    mode_t            ext, mode_after;
    logic [POS_W-1:0] start_after;
    logic             consumed, lwe_after;
    token_t           cand [NCAND];
    logic [NCAND-1:0] cand_vld;
    logic [1:0]       wr_idx [NCAND];
    logic [2:0]       push_n;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (count_reg <= 3'd1);
    assign m_tvalid = (count_reg != 3'd0);
    assign c        = s_tdata;

    // token candidates in emission order and the state after this character
    always_comb begin
        for (int k = 0; k < NCAND; k++) begin
            cand[k] = '0;
        end
        cand_vld    = '0;
        end_pos     = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : POS_MAX;
        ext         = extend_mode(mode_reg, c);
        consumed    = (mode_reg != MODE_IDLE) && (ext != MODE_IDLE);
        mode_after  = MODE_IDLE;
        start_after = start_reg;

        // open token closed by this character
        if (mode_reg != MODE_IDLE && ext == MODE_IDLE) begin
            cand_vld[0]    = 1'b1;
            cand[0].kind   = kind_of_mode(mode_reg);
            cand[0].start  = start_reg;
            cand[0].length = pos_reg - start_reg;
        end

        if (consumed) begin
            mode_after = ext;
        end else if (c == CH_SPACE || c == CH_TAB) begin
            mode_after = MODE_IDLE;
        end else if (is_digit(c)) begin
            mode_after  = MODE_INT;
            start_after = pos_reg;
        end else if (is_letter(c) || c == CH_UNDER) begin
            mode_after  = MODE_IDENT;
            start_after = pos_reg;
        end else if (c == CH_MINUS) begin
            mode_after  = MODE_OPT_MINUS;
            start_after = pos_reg;
        end else if (c == CH_PLUS) begin
            mode_after  = MODE_OPT_PLUS;
            start_after = pos_reg;
        end else begin
            // one-character token
            cand_vld[1]    = 1'b1;
            cand[1].start  = pos_reg;
            cand[1].length = POS_W'(1);
            if (c == CH_PIPE) cand[1].kind = KIND_PIPE;
            else if (c == CH_GT || c == CH_LT) cand[1].kind = KIND_REDIRECT;
            else if (c == CH_SEMI) cand[1].kind = KIND_EOL;
            else cand[1].kind = KIND_OPER;
        end

        // line end closes what is open
        if (s_tlast && mode_after != MODE_IDLE) begin
            cand_vld[2]    = 1'b1;
            cand[2].kind   = kind_of_mode(mode_after);
            cand[2].start  = start_after;
            cand[2].length = end_pos - start_after;
        end

        // end-of-line flag after the tokens above
        if (cand_vld[2]) lwe_after = 1'b0;
        else if (cand_vld[1]) lwe_after = (cand[1].kind == KIND_EOL);
        else if (cand_vld[0]) lwe_after = 1'b0;
        else lwe_after = lwe_reg;

        // appended end-of-line token
        if (s_tlast && !lwe_after) begin
            cand_vld[3]    = 1'b1;
            cand[3].kind   = KIND_EOL;
            cand[3].start  = end_pos;
            cand[3].length = '0;
        end

        // run end marks and queue slots
        push_n = '0;
        for (int k = 0; k < NCAND; k++) begin
            wr_idx[k]    = wptr_reg + push_n[1:0];
            cand[k].last = cand_vld[k] && ((cand_vld >> (k + 1)) == '0);
            push_n       = push_n + {2'b00, cand_vld[k]};
        end
    end

    // next lexer state
    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        lwe_next   = lwe_reg;
        if (accept) begin
            if (s_tlast) begin
                mode_next  = MODE_IDLE;
                start_next = '0;
                pos_next   = '0;
                lwe_next   = 1'b0;
            end else begin
                mode_next  = mode_after;
                start_next = start_after;
                pos_next   = end_pos;
                lwe_next   = lwe_after;
            end
        end
    end

    // queue pointers
    always_comb begin
        wptr_next  = accept ? wptr_reg + push_n[1:0] : wptr_reg;
        rptr_next  = pop ? rptr_reg + 2'd1 : rptr_reg;
        count_next = count_reg - {2'b00, pop} + (accept ? push_n : 3'd0);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            lwe_reg   <= 1'b0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            lwe_reg   <= lwe_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // token queue storage
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NCAND; k++) begin
            if (accept && cand_vld[k]) begin
                fifo_reg[wr_idx[k]] <= cand[k];
            end
        end
    end

    // result word
    always_comb begin
        m_tdata = {1'b0, fifo_reg[rptr_reg].length, fifo_reg[rptr_reg].start,
                   fifo_reg[rptr_reg].kind};
        m_tlast = fifo_reg[rptr_reg].last;
    end

endmodule

// File: src/cll_checker.sv
// ---------------------------------------------------------------------------
// cll_checker
// port-level checks on the command line lexer result stream
// ---------------------------------------------------------------------------
`include "command_line_lexer_core_macros.svh"

module cll_checker
    import cll_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  length;

    assign kind   = m_tdata[KIND_W-1:0];
    assign length = m_tdata[KIND_W+2*POS_W-1:KIND_W+POS_W];

    // a stalled word stays offered
    `CLL_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // a stalled word keeps its payload
    `CLL_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // single-character tokens are one long
    `CLL_ASSERT_IMP(a_single_len,
        m_tvalid && (kind == KIND_PIPE || kind == KIND_REDIRECT || kind == KIND_OPER),
        length == POS_W'(1))

    // end-of-line tokens are either ';' or appended with no length
    `CLL_ASSERT_IMP(a_eol_len, m_tvalid && kind == KIND_EOL,
        length == POS_W'(1) || length == '0)

    // reset empties the token queue
    `CLL_ASSERT_NXT_ANY(a_reset_empty, !aresetn, !m_tvalid)

endmodule

bind command_line_lexer_core cll_checker u_cll_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the command line lexer: characters go in one word
// at a time, a local token predictor builds the expected descriptors, and
// every token word leaving the block is compared field by field
// ---------------------------------------------------------------------------
module tb_top
    import cll_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int REPORT_MAX     = 10;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // predictor state
    mode_t      lex_state;
    logic [9:0] tok_start;
    logic [9:0] line_pos;
    logic       prev_was_eol;
    token_t     tokens_due[$];

    // stimulus control and bookkeeping
    int         src_idle_pct;
    int         sink_stall_pct;
    int         sink_hold_req;
    int         chars_sent;
    int         lines_sent;
    int         tokens_checked;
    int         mismatches;
    logic [7:0] line_buf[$];

    command_line_lexer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // token predictor
    // ---------------------------------------------------------------------

    function automatic bit char_is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit char_is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit char_is_word(input logic [7:0] c);
        return char_is_alpha(c) || char_is_digit(c) || c == CH_UNDER;
    endfunction

    // mode after c when it extends the open token, idle when it closes it
    function automatic mode_t grow_mode(input mode_t m, input logic [7:0] c);
        mode_t g;
        g = MODE_IDLE;
        case (m)
            MODE_INT: begin
                if (char_is_digit(c)) g = MODE_INT;
                else if (c == CH_DOT) g = MODE_FRAC;
            end
            MODE_FRAC: begin
                if (char_is_digit(c)) g = MODE_FRAC;
            end
            MODE_IDENT, MODE_SHORT, MODE_LONG: begin
                if (char_is_word(c)) g = m;
            end
            MODE_OPT_MINUS: begin
                if (c == CH_MINUS) g = MODE_LONG;
                else if (char_is_word(c)) g = MODE_SHORT;
            end
            MODE_OPT_PLUS: begin
                if (c == CH_PLUS) g = MODE_LONG;
                else if (char_is_word(c)) g = MODE_SHORT;
            end
            default: g = MODE_IDLE;
        endcase
        return g;
    endfunction

    function automatic logic [KIND_W-1:0] kind_for(input mode_t m);
        case (m)
            MODE_INT, MODE_FRAC: return KIND_NUMBER;
            MODE_IDENT:          return KIND_IDENT;
            MODE_LONG:           return KIND_LONG;
            default:             return KIND_SHORT;
        endcase
    endfunction

    function automatic void emit_token(input logic [KIND_W-1:0] k, input logic [9:0] st,
                                       input logic [9:0] len);
        token_t t;
        t.kind   = k;
        t.start  = st;
        t.length = len;
        t.last   = 1'b0;
        tokens_due = {tokens_due, t};
        prev_was_eol = (k == KIND_EOL);
    endfunction

    // advance the predictor by one accepted character word
    function automatic void lex_predict(input logic [7:0] c, input logic eol);
        logic [9:0] pos;
        logic [9:0] stop;
        mode_t      nxt;
        bit         taken;
        int         before_n;
        before_n = tokens_due.size();
        pos      = line_pos;
        stop     = (pos < POS_MAX) ? pos + 10'd1 : POS_MAX;
        taken    = 1'b0;

        // try to grow the open token first
        if (lex_state != MODE_IDLE) begin
            nxt = grow_mode(lex_state, c);
            if (nxt != MODE_IDLE) begin
                lex_state = nxt;
                taken     = 1'b1;
            end else begin
                emit_token(kind_for(lex_state), tok_start, pos - tok_start);
                lex_state = MODE_IDLE;
            end
        end

        // character starts something new
        if (!taken) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                // separator only
            end else if (char_is_digit(c)) begin
                lex_state = MODE_INT;
                tok_start = pos;
            end else if (char_is_alpha(c) || c == CH_UNDER) begin
                lex_state = MODE_IDENT;
                tok_start = pos;
            end else if (c == CH_PIPE) begin
                emit_token(KIND_PIPE, pos, 10'd1);
            end else if (c == CH_GT || c == CH_LT) begin
                emit_token(KIND_REDIRECT, pos, 10'd1);
            end else if (c == CH_SEMI) begin
                emit_token(KIND_EOL, pos, 10'd1);
            end else if (c == CH_MINUS) begin
                lex_state = MODE_OPT_MINUS;
                tok_start = pos;
            end else if (c == CH_PLUS) begin
                lex_state = MODE_OPT_PLUS;
                tok_start = pos;
            end else begin
                emit_token(KIND_OPER, pos, 10'd1);
            end
        end

        // line end closes everything and clears the line
        if (eol) begin
            if (lex_state != MODE_IDLE)
                emit_token(kind_for(lex_state), tok_start, stop - tok_start);
            if (!prev_was_eol)
                emit_token(KIND_EOL, stop, 10'd0);
            lex_state    = MODE_IDLE;
            tok_start    = '0;
            line_pos     = '0;
            prev_was_eol = 1'b0;
        end else begin
            line_pos = stop;
        end

        if (tokens_due.size() > before_n)
            tokens_due[tokens_due.size()-1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // character sender, entered and left at a falling edge
    // ---------------------------------------------------------------------

    task automatic send_char(input logic [7:0] c, input logic eol);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lex_predict(c, eol);
        chars_sent++;
        if (eol) lines_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_buf();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // stop offering and wait until every predicted token has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // token receiver and checker
    // ---------------------------------------------------------------------

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req > 0) begin
                // long hold-off, counted down here
                for (int n = sink_hold_req; n > 0; n--) begin
                    m_tready <= 1'b0;
                    if (n == sink_hold_req) sink_hold_req = 0;
                    @(negedge aclk);
                end
            end
            m_tready <= !aresetn ? 1'b0 :
                        (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("[%0t] token mismatch: %s", $realtime, what);
    endfunction

    always @(posedge aclk) begin
        token_t want;
        token_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tdata[2:0];
            got.start  = m_tdata[12:3];
            got.length = m_tdata[22:13];
            got.last   = m_tlast;
            tokens_checked++;
            if (tokens_due.size() == 0) begin
                note_mismatch($sformatf("unexpected kind %0d start %0d length %0d last %0b",
                                        got.kind, got.start, got.length, got.last));
            end else begin
                want = tokens_due.pop_front();
                if (got != want || m_tdata[23] !== 1'b0)
                    note_mismatch({
                        $sformatf("expected kind %0d start %0d length %0d last %0b, ",
                                  want.kind, want.start, want.length, want.last),
                        $sformatf("got kind %0d start %0d length %0d last %0b pad %0b",
                                  got.kind, got.start, got.length, got.last, m_tdata[23])});
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d tokens outstanding",
                 WATCHDOG_LIMIT, tokens_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // random line building
    // ---------------------------------------------------------------------

    function automatic void buf_add(input logic [7:0] c);
        line_buf = {line_buf, c};
    endfunction

    function automatic logic [7:0] rand_alpha();
        if ($urandom_range(1)) return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(3))
            0:       return 8'("0" + $urandom_range(9));
            1:       return CH_UNDER;
            default: return rand_alpha();
        endcase
    endfunction

    function automatic void add_separator();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) buf_add($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    // one lexeme with random content, a random raw byte or a separator
    function automatic void add_piece();
        int         n;
        logic [7:0] sign;
        case ($urandom_range(9))
            0: begin
                n = $urandom_range(1, 4);
                repeat (n) buf_add(8'("0" + $urandom_range(9)));
                if ($urandom_range(1)) begin
                    buf_add(CH_DOT);
                    n = $urandom_range(0, 3);
                    repeat (n) buf_add(8'("0" + $urandom_range(9)));
                end
            end
            1, 2: begin
                buf_add($urandom_range(4) == 0 ? CH_UNDER : rand_alpha());
                n = $urandom_range(0, 5);
                repeat (n) buf_add(rand_word_char());
            end
            3: begin
                sign = $urandom_range(1) ? CH_MINUS : CH_PLUS;
                buf_add(sign);
                case ($urandom_range(3))
                    0:       buf_add(sign);
                    1:       buf_add(sign == CH_MINUS ? CH_PLUS : CH_MINUS);
                    default: ;
                endcase
                n = $urandom_range(0, 4);
                repeat (n) buf_add(rand_word_char());
            end
            4: buf_add(CH_PIPE);
            5: buf_add($urandom_range(1) ? CH_GT : CH_LT);
            6: buf_add(CH_SEMI);
            7: buf_add(8'($urandom_range(255)));
            default: add_separator();
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // numbers, identifiers, second dot, redirect, pipe
    task automatic test_token_classes();
        send_line("x1 2.5.>");
        send_line("_a9|");
    endtask

    // short and long options, sign after option
    task automatic test_options();
        send_line("-v --a+-x ++");
    endtask

    // whitespace-only line, three tokens from one word, ';' ending a line
    task automatic test_line_ends();
        send_line(" ");
        send_line("ab|");
        send_line("a;");
        send_line("<");
        send_line("\t");
    endtask

    // nul and top-bit bytes are operators
    task automatic test_odd_bytes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // long line: offsets climb well past the short lines
    task automatic test_long_line();
        src_idle_pct   = 37;
        sink_stall_pct = 37;
        repeat (12) begin
            send_char("a", 1'b0);
            send_char("b", 1'b0);
            send_char("c", 1'b0);
            send_char(CH_SPACE, 1'b0);
        end
        repeat (5) send_char("q", 1'b0);
        send_char(CH_PIPE, 1'b0);
        send_char("-", 1'b0);
        send_char("7", 1'b1);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // receiver holds off so the token queue fills and input stalls
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = HOLD_CYCLES;
        send_line("a|b|c|d|e|f|g|h|i|j;");
        wait_drained();
    endtask

    // well-formed lines with random content, some raw noise mixed in
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_chars);
        int goal;
        int n;
        goal           = chars_sent + n_chars;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (chars_sent < goal) begin
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, 6);
                repeat (n) send_char(8'($urandom_range(255)), $urandom_range(5) == 0);
            end else begin
                n = $urandom_range(1, 5);
                if ($urandom_range(3) == 0) add_separator();
                repeat (n) begin
                    add_piece();
                    if ($urandom_range(1)) add_separator();
                end
                send_buf();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        aresetn        = 1'b0;
        lex_state      = MODE_IDLE;
        tok_start      = '0;
        line_pos       = '0;
        prev_was_eol   = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = 0;
        chars_sent     = 0;
        lines_sent     = 0;
        tokens_checked = 0;
        mismatches     = 0;

        // reset, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_token_classes();
        test_options();
        test_line_ends();
        test_odd_bytes();
        test_long_line();
        test_backpressure();
        test_random_traffic(0, 0, 50);
        test_random_traffic(73, 0, 50);
        test_random_traffic(0, 73, 50);
        test_random_traffic(37, 37, 50);
        test_random_traffic(0, 0, 15);

        // let the last tokens out
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tokens_due.size() != 0) begin
            $display("%0d predicted tokens never arrived", tokens_due.size());
            mismatches += tokens_due.size();
        end

        $display("covered %0d characters over %0d lines, %0d tokens checked, %0d mismatches",
                 chars_sent, lines_sent, tokens_checked, mismatches);
        $display("token classes, option signs, line ends, long lines, backpressure, idle mixes");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
